[rtl/core/assert_macros.svh]
// Assertion macros shared by the frame allocator RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is asserted
`define PFM_ASSERT_RST(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// clocked check that also holds through reset
`define PFM_ASSERT_CLK(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/pffm_pkg.sv]
// Types and constants of the page frame free list mapper
`timescale 1ns / 1ps

package pffm_pkg;

    localparam int NUM_FRAMES_DEF       = 1024;
    localparam int PAGES_PER_REGION_DEF = 512;

    localparam int OP_W         = 2;
    localparam int PAGE_W       = 9;
    localparam int PROT_W       = 3;
    localparam int FRAME_PORT_W = 10;
    localparam int COUNT_PORT_W = 11;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_DONATE = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic clear;
        logic capture;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
    } dp_stat_t;

endpackage

[rtl/core/pffm_ctrl.sv]
// Controller: page table clear after reset, then capture / commit per item
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pffm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  pffm_pkg::dp_stat_t stat,
    output pffm_pkg::dp_cmd_t  cmd
);
    import pffm_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
            end
            ST_IDLE:
            begin
                busy        = 1'b0;
                cmd.capture = start;
            end
            ST_EXEC:
            begin
                cmd.commit = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    `PFM_ASSERT_RST(a_commit_after_capture, cmd.commit |-> $past(cmd.capture), "commit without capture")
    `PFM_ASSERT_RST(a_clear_then_idle, (cmd.clear && stat.clear_last) |=> !busy, "clear pass did not end")
    `PFM_ASSERT_RST(a_capture_then_busy, cmd.capture |=> (busy && !cmd.capture), "item overlap")

endmodule

[rtl/core/pffm_dpath.sv]
// Datapath: page table and link memories, list head, free count, result
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pffm_dpath #(
    parameter int NUM_FRAMES       = pffm_pkg::NUM_FRAMES_DEF,
    parameter int PAGES_PER_REGION = pffm_pkg::PAGES_PER_REGION_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  pffm_pkg::dp_cmd_t                 cmd,
    output pffm_pkg::dp_stat_t                stat,
    input  logic [pffm_pkg::OP_W-1:0]         operation,
    input  logic                              region_sel,
    input  logic [pffm_pkg::PAGE_W-1:0]       virt_page,
    input  logic [pffm_pkg::PROT_W-1:0]       kernel_prot,
    input  logic [pffm_pkg::PROT_W-1:0]       user_prot,
    input  logic [pffm_pkg::FRAME_PORT_W-1:0] donated_frame,
    output logic                              done,
    output logic                              status,
    output logic [pffm_pkg::FRAME_PORT_W-1:0] frame_out,
    output logic [pffm_pkg::COUNT_PORT_W-1:0] frames_free
);
    import pffm_pkg::*;

    localparam int NUM_ENTRIES = 2 * PAGES_PER_REGION;
    localparam int EW          = $clog2(NUM_ENTRIES);
    localparam int FW          = $clog2(NUM_FRAMES);
    localparam int CW          = $clog2(NUM_FRAMES + 1);

    typedef struct packed {
        logic              valid;
        logic [PROT_W-1:0] kprot;
        logic [PROT_W-1:0] uprot;
        logic [FW-1:0]     frame;
    } entry_t;

    // input decode
    logic          page_ok_in;
    logic          don_ok_in;
    logic [EW-1:0] idx_in;

    assign page_ok_in = 32'(virt_page) < 32'(PAGES_PER_REGION);
    assign don_ok_in  = 32'(donated_frame) < 32'(NUM_FRAMES);
    assign idx_in     = region_sel ? EW'(32'(PAGES_PER_REGION) + 32'(virt_page))
                                   : EW'(32'(virt_page));

    // captured item
    op_t               op_reg;
    logic [EW-1:0]     idx_reg;
    logic              page_ok_reg;
    logic              don_ok_reg;
    logic [PROT_W-1:0] kprot_reg;
    logic [PROT_W-1:0] uprot_reg;
    logic [FW-1:0]     don_frame_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg        <= op_t'(operation);
            idx_reg       <= idx_in;
            page_ok_reg   <= page_ok_in;
            don_ok_reg    <= don_ok_in;
            kprot_reg     <= kernel_prot;
            uprot_reg     <= user_prot;
            don_frame_reg <= FW'(donated_frame);
        end
    end

    // control state
    logic [FW-1:0] list_head_reg;
    logic [FW-1:0] list_head_next;
    logic [CW-1:0] free_cnt_reg;
    logic [CW-1:0] free_cnt_next;
    logic [EW-1:0] clr_cnt_reg;
    logic [EW-1:0] clr_cnt_next;
    logic          done_reg;

    // memories
    entry_t        entry_mem [NUM_ENTRIES];
    entry_t        entry_rd_reg;
    logic [FW-1:0] link_mem [NUM_FRAMES];
    logic [FW-1:0] link_rd_reg;

    logic          ent_we;
    entry_t        ent_wdata;
    logic          link_we;
    logic [FW-1:0] link_waddr;
    logic          status_next;
    logic [FW-1:0] frame_next;
    logic          status_reg;
    logic [FW-1:0] frame_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            entry_mem[clr_cnt_reg] <= '0;
        end
        else if (ent_we)
        begin
            entry_mem[idx_reg] <= ent_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            entry_rd_reg <= entry_mem[idx_in];
        end
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= list_head_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            link_rd_reg <= link_mem[list_head_reg];
        end
    end

    // commit: pop on allocate, push on free and donate
    always_comb
    begin
        ent_we         = 1'b0;
        ent_wdata      = entry_rd_reg;
        link_we        = 1'b0;
        link_waddr     = don_frame_reg;
        list_head_next = list_head_reg;
        free_cnt_next  = free_cnt_reg;
        status_next    = 1'b0;
        frame_next     = '0;
        if (cmd.commit)
        begin
            unique case (op_reg)
                OP_ALLOC:
                begin
                    if (free_cnt_reg == '0)
                    begin
                        status_next = 1'b1;
                    end
                    else if (page_ok_reg)
                    begin
                        ent_we          = 1'b1;
                        ent_wdata.valid = 1'b1;
                        ent_wdata.kprot = kprot_reg;
                        ent_wdata.uprot = uprot_reg;
                        ent_wdata.frame = list_head_reg;
                        list_head_next  = link_rd_reg;
                        free_cnt_next   = free_cnt_reg - 1'b1;
                        frame_next      = list_head_reg;
                    end
                end
                OP_FREE:
                begin
                    if (page_ok_reg && entry_rd_reg.valid
                        && free_cnt_reg < CW'(NUM_FRAMES))
                    begin
                        ent_we          = 1'b1;
                        ent_wdata.valid = 1'b0;
                        link_we         = 1'b1;
                        link_waddr      = entry_rd_reg.frame;
                        list_head_next  = entry_rd_reg.frame;
                        free_cnt_next   = free_cnt_reg + 1'b1;
                        frame_next      = entry_rd_reg.frame;
                    end
                end
                OP_DONATE:
                begin
                    if (don_ok_reg && free_cnt_reg < CW'(NUM_FRAMES))
                    begin
                        link_we        = 1'b1;
                        link_waddr     = don_frame_reg;
                        list_head_next = don_frame_reg;
                        free_cnt_next  = free_cnt_reg + 1'b1;
                        frame_next     = don_frame_reg;
                    end
                end
                default:
                begin
                    status_next = 1'b0;
                end
            endcase
        end
    end

    assign clr_cnt_next = cmd.clear ? EW'(clr_cnt_reg + 1'b1) : clr_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_head_reg <= '0;
            free_cnt_reg  <= '0;
            clr_cnt_reg   <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            list_head_reg <= list_head_next;
            free_cnt_reg  <= free_cnt_next;
            clr_cnt_reg   <= clr_cnt_next;
            done_reg      <= cmd.commit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            status_reg <= status_next;
            frame_reg  <= frame_next;
        end
    end

    assign stat.clear_last = clr_cnt_reg == EW'(NUM_ENTRIES - 1);

    // count only moves on commit, so it is current during the done cycle
    assign done        = done_reg;
    assign status      = status_reg;
    assign frame_out   = FRAME_PORT_W'(frame_reg);
    assign frames_free = COUNT_PORT_W'(free_cnt_reg);

    `PFM_ASSERT_CLK(a_count_bound, !rst_n || free_cnt_reg <= CW'(NUM_FRAMES), "free count above frame total")
    `PFM_ASSERT_RST(a_count_on_commit, !cmd.commit |=> $stable(free_cnt_reg), "count moved without commit")
    `PFM_ASSERT_RST(a_fail_keeps_list, (done_reg && status_reg) |-> $stable(list_head_reg), "failed allocate moved head")

endmodule

[rtl/core/page_frame_free_list_mapper_core.sv]
// Top level of the page frame free list mapper
`timescale 1ns / 1ps

// Frame allocator with a two-region page table. After reset, busy stays high
// while the page table is swept clear. Then an item is taken when start is
// high and busy low; busy is high for the next cycle, and the result shows on
// status, frame_out and frames_free for exactly one cycle with done high, the
// cycle after that. Each item runs in two steps, and no new item is taken
// before its commit step: the first step reads the page table entry and the
// free list link at the head, the second writes them back and moves the head.
// done cannot be held off; a result must be taken in its cycle.
module page_frame_free_list_mapper_core #(
    parameter int NUM_FRAMES       = pffm_pkg::NUM_FRAMES_DEF,
    parameter int PAGES_PER_REGION = pffm_pkg::PAGES_PER_REGION_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [pffm_pkg::OP_W-1:0]         operation,
    input  logic                              region_sel,
    input  logic [pffm_pkg::PAGE_W-1:0]       virt_page,
    input  logic [pffm_pkg::PROT_W-1:0]       kernel_prot,
    input  logic [pffm_pkg::PROT_W-1:0]       user_prot,
    input  logic [pffm_pkg::FRAME_PORT_W-1:0] donated_frame,
    output logic                              done,
    output logic                              status,
    output logic [pffm_pkg::FRAME_PORT_W-1:0] frame_out,
    output logic [pffm_pkg::COUNT_PORT_W-1:0] frames_free
);
    import pffm_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    pffm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    pffm_dpath #(
        .NUM_FRAMES       (NUM_FRAMES),
        .PAGES_PER_REGION (PAGES_PER_REGION)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .operation     (operation),
        .region_sel    (region_sel),
        .virt_page     (virt_page),
        .kernel_prot   (kernel_prot),
        .user_prot     (user_prot),
        .donated_frame (donated_frame),
        .done          (done),
        .status        (status),
        .frame_out     (frame_out),
        .frames_free   (frames_free)
    );

endmodule
